FILE: rtl/ppmfd_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package ppmfd_pkg;

  // Number of channels in one PPM frame.
  localparam int unsigned CHANNEL_COUNT = 8;

  // The channel index counts 0..CHANNEL_COUNT, so it needs one extra code.
  localparam int unsigned NEXT_CH_W = $clog2(CHANNEL_COUNT + 1);

  // Field widths.
  localparam int unsigned TIME_W  = 32;
  localparam int unsigned WIDTH_W = 16;
  localparam int unsigned CHAN_W  = 3;
  localparam int unsigned AXIS_W  = 10;

  // Sync gap after reset, in microseconds.
  localparam logic [WIDTH_W-1:0] SYNC_GAP_RESET = 16'd4000;

  // Axis clamp limits in microseconds.
  localparam logic [WIDTH_W-1:0] AXIS_MIN_US = 16'd1000;
  localparam logic [WIDTH_W-1:0] AXIS_MAX_US = 16'd2000;

  // (d * 1023) / 1000 is computed as (d * 1023 * ceil(2^30 / 1000)) >> 30.
  // This is exact for every d in 0..1000.
  localparam int unsigned        AXIS_SHIFT = 30;
  localparam int unsigned        RECIP_W    = 31;
  localparam logic [RECIP_W-1:0] AXIS_RECIP = 31'd1098438066;

  // Depth of the queue between the front and back parts.
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One classified channel measurement.
  typedef struct packed {
    logic [CHAN_W-1:0]  channel;
    logic [WIDTH_W-1:0] width;
    logic               last;
  } item_t;

endpackage

`default_nettype wire

FILE: rtl/ppmfd_front.sv
`timescale 1ns / 1ps
`default_nettype none

module ppmfd_front
  import ppmfd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [WIDTH_W-1:0] cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [TIME_W-1:0]  edge_time_i,
  output logic                    push_o,
  output item_t                   push_item_o,
  input  wire logic               q_full_i
);

  logic [WIDTH_W-1:0]   sync_gap_q;
  logic [TIME_W-1:0]    prev_time_q, prev_time_d;
  logic [NEXT_CH_W-1:0] next_ch_q, next_ch_d;
  logic [TIME_W-1:0]    interval;
  logic                 accept;
  logic                 is_sync;
  logic                 frame_done;

  // An edge is taken whenever the queue has room.
  assign in_stall_o = q_full_i;
  assign accept     = in_valid_i & ~q_full_i;

  // Classify the edge: sync gap, channel pulse, or ignored after frame end.
  assign interval   = edge_time_i - prev_time_q;
  assign is_sync    = interval > {{(TIME_W-WIDTH_W){1'b0}}, sync_gap_q};
  assign frame_done = next_ch_q >= NEXT_CH_W'(CHANNEL_COUNT);

  always_comb begin
    prev_time_d = prev_time_q;
    next_ch_d   = next_ch_q;
    push_o      = 1'b0;
    if (accept) begin
      prev_time_d = edge_time_i;
      if (is_sync) begin
        next_ch_d = '0;
      end else if (!frame_done) begin
        next_ch_d = next_ch_q + NEXT_CH_W'(1);
        push_o    = 1'b1;
      end
    end
  end

  // Payload of the channel measurement; the width saturates at its maximum.
  always_comb begin
    push_item_o.channel = CHAN_W'(next_ch_q);
    push_item_o.width   = (|interval[TIME_W-1:WIDTH_W]) ? '1 : interval[WIDTH_W-1:0];
    push_item_o.last    = next_ch_q == NEXT_CH_W'(CHANNEL_COUNT - 1);
  end

  // Edge time, channel index and the sync gap register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prev_time_q <= '0;
      next_ch_q   <= '0;
      sync_gap_q  <= SYNC_GAP_RESET;
    end else begin
      prev_time_q <= prev_time_d;
      next_ch_q   <= next_ch_d;
      if (cfg_we_i) begin
        sync_gap_q <= cfg_wdata_i;
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ppmfd_queue.sv
`timescale 1ns / 1ps
`default_nettype none

module ppmfd_queue
  import ppmfd_pkg::*;
(
  input  wire logic  clk_i,
  input  wire logic  rst_ni,
  input  wire logic  push_i,
  input  wire item_t push_item_i,
  output logic       full_o,
  output logic       valid_o,
  output item_t      item_o,
  input  wire logic  pop_i
);

  item_t             mem_q [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QCNT_W-1:0] count_q;

  assign full_o  = count_q == QCNT_W'(QUEUE_DEPTH);
  assign valid_o = count_q != '0;
  assign item_o  = mem_q[rd_ptr_q];

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + QCNT_W'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - QCNT_W'(1);
      end
    end
  end

endmodule

`default_nettype wire

FILE: rtl/ppmfd_back.sv
`timescale 1ns / 1ps
`default_nettype none

module ppmfd_back
  import ppmfd_pkg::*;
(
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              q_valid_i,
  input  wire item_t             q_item_i,
  output logic                   q_pop_o,
  output logic                   out_valid_o,
  input  wire logic              out_stall_i,
  output logic [CHAN_W-1:0]      channel_number_o,
  output logic [WIDTH_W-1:0]     pulse_width_o,
  output logic [AXIS_W-1:0]      axis_value_o,
  output logic                   frame_last_o
);

  logic                        out_valid_q;
  logic [CHAN_W-1:0]           channel_q;
  logic [WIDTH_W-1:0]          width_q;
  logic [AXIS_W-1:0]           axis_q;
  logic                        last_q;
  logic [WIDTH_W-1:0]          clamped;
  logic [AXIS_W-1:0]           offset;
  logic [AXIS_W+RECIP_W-1:0]   product;
  logic [AXIS_W-1:0]           axis_d;

  // Take the next entry when the output register is empty or being drained.
  assign q_pop_o = q_valid_i & (~out_valid_q | ~out_stall_i);

  // Clamp to the stick range and scale to 0..1023 by reciprocal multiplication.
  always_comb begin
    if (q_item_i.width < AXIS_MIN_US) begin
      clamped = AXIS_MIN_US;
    end else if (q_item_i.width > AXIS_MAX_US) begin
      clamped = AXIS_MAX_US;
    end else begin
      clamped = q_item_i.width;
    end
    offset  = AXIS_W'(clamped - AXIS_MIN_US);
    product = (AXIS_W + RECIP_W)'(offset) * (AXIS_W + RECIP_W)'(AXIS_RECIP);
    axis_d  = product[AXIS_SHIFT +: AXIS_W];
  end

  // Output valid flag.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (q_pop_o) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output payload, loaded with each popped entry.
  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      channel_q <= q_item_i.channel;
      width_q   <= q_item_i.width;
      axis_q    <= axis_d;
      last_q    <= q_item_i.last;
    end
  end

  assign out_valid_o      = out_valid_q;
  assign channel_number_o = channel_q;
  assign pulse_width_o    = width_q;
  assign axis_value_o     = axis_q;
  assign frame_last_o     = last_q;

endmodule

`default_nettype wire

FILE: rtl/ppm_frame_decoder_core.sv
`timescale 1ns / 1ps
`default_nettype none

// Decodes an RC PPM pulse train from the microsecond timestamps of its rising
// edges. Every edge that is not stalled is taken, one per clock cycle. An
// interval since the previous edge above the sync gap starts a new frame and
// gives no result; each following edge gives one result per channel until the
// frame's channels are done, and later edges are dropped until the next sync.
// A result carries the channel number, the raw width saturated at 65535, the
// width clamped to 1000..2000 us and scaled to 0..1023, and a flag on the last
// channel. The front part takes one edge per cycle while the queue has room, with
// its 32-bit interval subtract and sync compare; a result goes through a two-entry
// queue, which lets input and output stall on their own, and the output register.
// The sync gap register resets to 4000 us and is written through cfg_we_i.
module ppm_frame_decoder_core
  import ppmfd_pkg::*;
(
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               cfg_we_i,
  input  wire logic [WIDTH_W-1:0] cfg_wdata_i,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [TIME_W-1:0]  edge_time_i,
  output logic                    out_valid_o,
  input  wire logic               out_stall_i,
  output logic [CHAN_W-1:0]       channel_number_o,
  output logic [WIDTH_W-1:0]      pulse_width_o,
  output logic [AXIS_W-1:0]       axis_value_o,
  output logic                    frame_last_o
);

  logic  push;
  item_t push_item;
  logic  q_full;
  logic  q_valid;
  item_t q_item;
  logic  q_pop;

  // Edge classification and channel tracking.
  ppmfd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .edge_time_i (edge_time_i),
    .push_o      (push),
    .push_item_o (push_item),
    .q_full_i    (q_full)
  );

  // Decoupling queue between the two parts.
  ppmfd_queue u_queue (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .push_item_i (push_item),
    .full_o      (q_full),
    .valid_o     (q_valid),
    .item_o      (q_item),
    .pop_i       (q_pop)
  );

  // Axis scaling and output register.
  ppmfd_back u_back (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .q_valid_i        (q_valid),
    .q_item_i         (q_item),
    .q_pop_o          (q_pop),
    .out_valid_o      (out_valid_o),
    .out_stall_i      (out_stall_i),
    .channel_number_o (channel_number_o),
    .pulse_width_o    (pulse_width_o),
    .axis_value_o     (axis_value_o),
    .frame_last_o     (frame_last_o)
  );

endmodule

`default_nettype wire
